[hdl/hrp_pkg.sv]
// Shared types and constants for the HTTP request head parser.
// Limits, parse phases, result kinds and reject reasons; no dependencies.
`timescale 1ns / 1ps

package hrp_pkg;

	// Field length limits: a field holds at most LIMIT-1 bytes
	localparam int METHOD_LIMIT  = 16;
	localparam int PATH_LIMIT    = 256;
	localparam int VERSION_LIMIT = 16;
	localparam int HEADER_LIMIT  = 32;
	localparam int NAME_LIMIT    = 64;
	localparam int VALUE_LIMIT   = 256;

	localparam int MAX_A     = (METHOD_LIMIT > PATH_LIMIT) ? METHOD_LIMIT : PATH_LIMIT;
	localparam int MAX_B     = (VERSION_LIMIT > NAME_LIMIT) ? VERSION_LIMIT : NAME_LIMIT;
	localparam int MAX_C     = (MAX_A > MAX_B) ? MAX_A : MAX_B;
	localparam int MAX_LIMIT = (MAX_C > VALUE_LIMIT) ? MAX_C : VALUE_LIMIT;

	// field length counter and header counter widths
	localparam int LEN_W = $clog2(MAX_LIMIT);
	localparam int HS_W  = $clog2(HEADER_LIMIT + 1);

	// byte codes
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// result kinds
	localparam logic [2:0] KIND_METHOD  = 3'd0;
	localparam logic [2:0] KIND_PATH    = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_NAME    = 3'd3;
	localparam logic [2:0] KIND_VALUE   = 3'd4;
	localparam logic [2:0] KIND_HDONE   = 3'd5;
	localparam logic [2:0] KIND_ACCEPT  = 3'd6;
	localparam logic [2:0] KIND_REJECT  = 3'd7;

	// reject reasons
	localparam logic [2:0] RSN_NONE      = 3'd0;
	localparam logic [2:0] RSN_ENDED     = 3'd1;
	localparam logic [2:0] RSN_MALFORMED = 3'd2;
	localparam logic [2:0] RSN_TOO_LONG  = 3'd3;
	localparam logic [2:0] RSN_TOO_MANY  = 3'd4;
	localparam logic [2:0] RSN_NO_COLON  = 3'd5;

	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_PATH    = 3'd1,
		PH_VERSION = 3'd2,
		PH_NAME    = 3'd3,
		PH_VSKIP   = 3'd4,
		PH_VALUE   = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic              cr_held;
		logic [LEN_W-1:0]  flen;
		logic [HS_W-1:0]   hseen;
	} pstate_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] idx;
		logic [7:0] data;
		logic [2:0] reason;
	} res_t;

	localparam pstate_t PSTATE_RESET = '{phase: PH_METHOD, cr_held: 1'b0,
		flen: '0, hseen: '0};

endpackage

[hdl/hrp_step.sv]
// Next-state and result logic for one request byte (combinational).
// Depends on hrp_pkg; yields up to three results per byte.
`timescale 1ns / 1ps

module hrp_step
	import hrp_pkg::*;
(
	input  pstate_t    cur,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output pstate_t    nxt,
	output res_t       res [3],
	output logic [1:0] cnt
);

	typedef struct packed {
		pstate_t st;
		logic    emit;
		res_t    res;
	} bstep_t;

	function automatic res_t mk_reject(input logic [2:0] reason);
		res_t r;
		r = '{kind: KIND_REJECT, idx: 5'd0, data: 8'd0, reason: reason};
		return r;
	endfunction

	// one content byte in the current phase
	function automatic bstep_t byte_in(input pstate_t s, input logic [7:0] b);
		bstep_t o;
		logic [LEN_W-1:0] lim_m1;
		o.st   = s;
		o.emit = 1'b0;
		o.res  = '0;
		if (s.phase == PH_NAME && s.flen == '0 && s.hseen >= HS_W'(HEADER_LIMIT)) begin
			o.st.cr_held = 1'b0;
			o.st.phase   = PH_DONE;
			o.emit       = 1'b1;
			o.res        = mk_reject(RSN_TOO_MANY);
		end else if (b == CH_SPACE && (s.phase == PH_METHOD || s.phase == PH_PATH)) begin
			o.st.phase = (s.phase == PH_METHOD) ? PH_PATH : PH_VERSION;
			o.st.flen  = '0;
		end else if (b == CH_COLON && s.phase == PH_NAME) begin
			o.st.phase = PH_VSKIP;
			o.st.flen  = '0;
		end else if (!(s.phase == PH_VSKIP && b == CH_SPACE)) begin
			if (s.phase == PH_VSKIP)
				o.st.phase = PH_VALUE;
			case (o.st.phase)
				PH_METHOD:  lim_m1 = LEN_W'(METHOD_LIMIT - 1);
				PH_PATH:    lim_m1 = LEN_W'(PATH_LIMIT - 1);
				PH_VERSION: lim_m1 = LEN_W'(VERSION_LIMIT - 1);
				PH_NAME:    lim_m1 = LEN_W'(NAME_LIMIT - 1);
				default:    lim_m1 = LEN_W'(VALUE_LIMIT - 1);
			endcase
			if (s.flen >= lim_m1) begin
				o.st.cr_held = 1'b0;
				o.st.phase   = PH_DONE;
				o.emit       = 1'b1;
				o.res        = mk_reject(RSN_TOO_LONG);
			end else begin
				o.st.flen    = s.flen + LEN_W'(1);
				o.emit       = 1'b1;
				o.res.data   = b;
				o.res.reason = RSN_NONE;
				case (o.st.phase)
					PH_NAME: begin
						o.res.kind = KIND_NAME;
						o.res.idx  = 5'(s.hseen);
					end
					PH_VALUE: begin
						o.res.kind = KIND_VALUE;
						o.res.idx  = 5'(s.hseen);
					end
					PH_PATH: begin
						o.res.kind = KIND_PATH;
						o.res.idx  = 5'd0;
					end
					PH_VERSION: begin
						o.res.kind = KIND_VERSION;
						o.res.idx  = 5'd0;
					end
					default: begin
						o.res.kind = KIND_METHOD;
						o.res.idx  = 5'd0;
					end
				endcase
			end
		end
		return o;
	endfunction

	// CR LF seen: close the current line
	function automatic bstep_t close_line(input pstate_t s);
		bstep_t o;
		o.st   = s;
		o.emit = 1'b0;
		o.res  = '0;
		case (s.phase)
			PH_METHOD, PH_PATH: begin
				o.st.cr_held = 1'b0;
				o.st.phase   = PH_DONE;
				o.emit       = 1'b1;
				o.res        = mk_reject(RSN_MALFORMED);
			end
			PH_VERSION: begin
				o.st.phase = PH_NAME;
				o.st.flen  = '0;
				o.st.hseen = '0;
			end
			PH_NAME: begin
				o.st.phase = PH_DONE;
				o.emit     = 1'b1;
				if (s.flen == '0) begin
					o.res = '{kind: KIND_ACCEPT, idx: 5'd0, data: 8'd0, reason: RSN_NONE};
				end else begin
					o.st.cr_held = 1'b0;
					o.res        = mk_reject(RSN_NO_COLON);
				end
			end
			default: begin
				o.emit     = 1'b1;
				o.res      = '{kind: KIND_HDONE, idx: 5'(s.hseen), data: 8'd0,
					reason: RSN_NONE};
				o.st.hseen = s.hseen + HS_W'(1);
				o.st.phase = PH_NAME;
				o.st.flen  = '0;
			end
		endcase
		return o;
	endfunction

	// walk the byte: held CR first, then the byte itself, then buffer end
	always_comb begin
		pstate_t    s;
		bstep_t     bs;
		logic       handled;
		logic [1:0] n;
		s       = cur;
		n       = 2'd0;
		handled = 1'b0;
		bs      = '0;
		for (int i = 0; i < 3; i++)
			res[i] = '0;

		if (s.phase != PH_DONE) begin
			if (in_byte == CH_NUL) begin
				s.cr_held = 1'b0;
				s.phase   = PH_DONE;
				res[n]    = mk_reject(RSN_ENDED);
				n         = n + 2'd1;
			end else begin
				if (s.cr_held) begin
					s.cr_held = 1'b0;
					if (in_byte == CH_LF) begin
						bs      = close_line(s);
						handled = 1'b1;
					end else begin
						bs = byte_in(s, CH_CR);
						if (bs.st.phase == PH_DONE)
							handled = 1'b1;
					end
					s = bs.st;
					if (bs.emit) begin
						res[n] = bs.res;
						n      = n + 2'd1;
					end
				end
				if (!handled) begin
					if (in_byte == CH_CR) begin
						s.cr_held = 1'b1;
					end else begin
						bs = byte_in(s, in_byte);
						s  = bs.st;
						if (bs.emit) begin
							res[n] = bs.res;
							n      = n + 2'd1;
						end
					end
				end
			end
		end

		// buffer end: reject if no verdict yet, then start over
		if (in_last) begin
			if (s.phase != PH_DONE) begin
				res[n] = mk_reject(RSN_ENDED);
				n      = n + 2'd1;
			end
			s = PSTATE_RESET;
		end

		nxt = s;
		cnt = n;
	end

endmodule

[hdl/http_request_head_parser_core.sv]
// HTTP request head parser top level: input register, step logic, result buffer.
// Depends on hrp_pkg and hrp_step.
`timescale 1ns / 1ps
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------------
//  in      | in_valid, in_stall | in_byte, in_last
//  out     | out_valid,out_stall| result_kind, header_index, out_byte, error_reason,
//          |                    | last_result
//
//  A byte is registered on acceptance and parsed once the result buffer is free;
//  its results (0 to 3) land in a three-slot result buffer that drains one beat per
//  cycle while out_stall is low. Bytes giving at most one result flow at one beat per
//  cycle while out_stall is low; a byte giving more results holds the input until
//  its last result leaves the buffer.
//  arst_n clears the parse state and both valid flags at once.
//  out_stall backs up through the result buffer into in_stall in the same cycle.

module http_request_head_parser_core
	import hrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] result_kind,
	output logic [4:0] header_index,
	output logic [7:0] out_byte,
	output logic [2:0] error_reason,
	output logic       last_result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	pstate_t    st_q;
	pstate_t    st_nxt;
	res_t       step_res [3];
	logic [1:0] step_cnt;

	res_t       slot_q [3];
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] remain;
	logic       consume;

	// result buffer handshake
	assign pop     = (cnt_q != 2'd0) && !out_stall;
	assign remain  = cnt_q - {1'b0, pop};
	assign consume = valid_s1 && (remain == 2'd0);
	assign in_stall = valid_s1 && !consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	hrp_step u_step (
		.cur     (st_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.nxt     (st_nxt),
		.res     (step_res),
		.cnt     (step_cnt)
	);

	// parse state advances when the registered byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PSTATE_RESET;
		end else if (consume) begin
			st_q <= st_nxt;
		end
	end

	// result buffer: load a byte's results, else shift out one per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (consume) begin
			cnt_q <= step_cnt;
		end else begin
			cnt_q <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			slot_q[0] <= step_res[0];
			slot_q[1] <= step_res[1];
			slot_q[2] <= step_res[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	assign out_valid    = (cnt_q != 2'd0);
	assign result_kind  = slot_q[0].kind;
	assign header_index = slot_q[0].idx;
	assign out_byte     = slot_q[0].data;
	assign error_reason = slot_q[0].reason;
	assign last_result  = (cnt_q == 2'd1);

	// checks
	a_done_no_cr: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_DONE |-> !st_q.cr_held)
		else $error("CR still held after a verdict");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> (st_q.phase == PH_METHOD && !st_q.cr_held &&
			st_q.flen == '0 && st_q.hseen == '0))
		else $error("parse state not cleared after buffer end");

	a_hseen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.hseen <= HS_W'(HEADER_LIMIT))
		else $error("header count beyond limit");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for http_request_head_parser_core: byte stream in, tagged results out.
// Depends on hrp_pkg (limits, byte codes, kinds, reasons, phases) and the core itself.
`timescale 1ns / 1ps

module testbench;
	import hrp_pkg::*;

	localparam int STIM_TARGET  = 170;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam longint WATCHDOG_NS = 5_000_000;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] idx;
		logic [7:0] data;
		logic [2:0] reason;
		logic       last;
	} result_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] result_kind;
	logic [4:0] header_index;
	logic [7:0] out_byte;
	logic [2:0] error_reason;
	logic       last_result;

	http_request_head_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.header_index(header_index),
		.out_byte(out_byte),
		.error_reason(error_reason),
		.last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and scoreboard state
	beat_t        request_beats[$];
	result_beat_t expected_results[$];
	result_beat_t step_results[$];
	int           beats_total;
	int           beats_accepted = 0;
	int           results_seen = 0;
	int           errors = 0;
	int           kinds_seen[8];
	int           reasons_seen[8];
	logic         in_fire = 1'b0;
	logic         hold_off = 1'b0;

	// parser shadow state
	phase_t       pr_phase = PH_METHOD;
	logic         pr_cr = 1'b0;
	int           pr_len = 0;
	int           pr_hdrs = 0;

	// ---------------------------------------------------------------
	// Parser prediction
	// ---------------------------------------------------------------

	function void parse_reset();
		pr_phase = PH_METHOD;
		pr_cr = 1'b0;
		pr_len = 0;
		pr_hdrs = 0;
	endfunction

	function void push_result(logic [2:0] kind, int idx, logic [7:0] data, logic [2:0] reason);
		result_beat_t r;
		r.kind = kind;
		r.idx = 5'(idx);
		r.data = data;
		r.reason = reason;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function void reject_request(logic [2:0] reason);
		pr_cr = 1'b0;
		pr_phase = PH_DONE;
		push_result(KIND_REJECT, 0, 8'h00, reason);
	endfunction

	function int field_cap(phase_t ph);
		case (ph)
			PH_METHOD:  return METHOD_LIMIT;
			PH_PATH:    return PATH_LIMIT;
			PH_VERSION: return VERSION_LIMIT;
			PH_NAME:    return NAME_LIMIT;
			default:    return VALUE_LIMIT;
		endcase
	endfunction

	// one content byte (a held CR passed on as content included)
	function void take_content(logic [7:0] b);
		logic [2:0] kind;
		int idx;
		idx = 0;
		if (pr_phase == PH_NAME && pr_len == 0 && pr_hdrs >= HEADER_LIMIT) begin
			reject_request(RSN_TOO_MANY);
			return;
		end
		if (b == CH_SPACE && (pr_phase == PH_METHOD || pr_phase == PH_PATH)) begin
			pr_phase = (pr_phase == PH_METHOD) ? PH_PATH : PH_VERSION;
			pr_len = 0;
			return;
		end
		if (b == CH_COLON && pr_phase == PH_NAME) begin
			pr_phase = PH_VSKIP;
			pr_len = 0;
			return;
		end
		if (pr_phase == PH_VSKIP) begin
			if (b == CH_SPACE)
				return;
			pr_phase = PH_VALUE;
		end
		if (pr_len + 1 >= field_cap(pr_phase)) begin
			reject_request(RSN_TOO_LONG);
			return;
		end
		pr_len++;
		case (pr_phase)
			PH_NAME: begin
				kind = KIND_NAME;
				idx = pr_hdrs;
			end
			PH_VALUE: begin
				kind = KIND_VALUE;
				idx = pr_hdrs;
			end
			PH_PATH:    kind = KIND_PATH;
			PH_VERSION: kind = KIND_VERSION;
			default:    kind = KIND_METHOD;
		endcase
		push_result(kind, idx, b, RSN_NONE);
	endfunction

	// CR LF seen
	function void line_complete();
		case (pr_phase)
			PH_METHOD, PH_PATH: reject_request(RSN_MALFORMED);
			PH_VERSION: begin
				pr_phase = PH_NAME;
				pr_len = 0;
				pr_hdrs = 0;
			end
			PH_NAME: begin
				if (pr_len == 0) begin
					pr_phase = PH_DONE;
					push_result(KIND_ACCEPT, 0, 8'h00, RSN_NONE);
				end else
					reject_request(RSN_NO_COLON);
			end
			default: begin
				push_result(KIND_HDONE, pr_hdrs, 8'h00, RSN_NONE);
				pr_hdrs++;
				pr_phase = PH_NAME;
				pr_len = 0;
			end
		endcase
	endfunction

	// expected results of one accepted input beat
	function void predict_beat(logic [7:0] b, logic last);
		logic handled;
		result_beat_t r;
		step_results.delete();
		handled = 1'b0;
		if (pr_phase != PH_DONE) begin
			if (b == CH_NUL)
				reject_request(RSN_ENDED);
			else begin
				if (pr_cr) begin
					pr_cr = 1'b0;
					if (b == CH_LF) begin
						line_complete();
						handled = 1'b1;
					end else begin
						take_content(CH_CR);
						if (pr_phase == PH_DONE)
							handled = 1'b1;
					end
				end
				if (!handled) begin
					if (b == CH_CR)
						pr_cr = 1'b1;
					else
						take_content(b);
				end
			end
		end
		if (last) begin
			if (pr_phase != PH_DONE)
				reject_request(RSN_ENDED);
			parse_reset();
		end
		if (step_results.size() > 0) begin
			r = step_results[step_results.size() - 1];
			r.last = 1'b1;
			step_results[step_results.size() - 1] = r;
		end
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endfunction

	// ---------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------

	function void add_beat(logic [7:0] b, logic last);
		beat_t t;
		t.b = b;
		t.last = last;
		request_beats.push_back(t);
	endfunction

	function void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_beat(s[i], 1'b0);
	endfunction

	function void add_crlf();
		add_beat(CH_CR, 1'b0);
		add_beat(CH_LF, 1'b0);
	endfunction

	function void mark_last();
		beat_t t;
		t = request_beats[request_beats.size() - 1];
		t.last = 1'b1;
		request_beats[request_beats.size() - 1] = t;
	endfunction

	// mostly letters, some arbitrary bytes; loose fields also get delimiters
	function logic [7:0] text_byte(logic loose);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 8'(8'h61 + $urandom_range(0, 25));
		if (r < 8)
			return 8'($urandom_range(1, 255));
		if (!loose)
			return 8'h2d;
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_COLON;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function void add_field(int n, logic loose);
		for (int i = 0; i < n; i++)
			add_beat(text_byte(loose), 1'b0);
	endfunction

	// short fields mostly; small-limit fields now and then right at the limit
	function int field_len(int cap);
		if (cap <= 64 && $urandom_range(0, 15) == 0)
			return $urandom_range(cap - 2, cap);
		return $urandom_range(0, 6);
	endfunction

	function int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// ---------------------------------------------------------------
	// Input driver
	// ---------------------------------------------------------------

	int    send_gap = 0;
	int    send_calm = 0;
	beat_t drv_beat;

	always @(negedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (request_beats.size() > 0) begin
				drv_beat = request_beats.pop_front();
				in_byte <= drv_beat.b;
				in_last <= drv_beat.last;
				in_valid <= 1'b1;
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					if ($urandom_range(0, 39) == 0)
						send_calm = $urandom_range(15, 40);
					send_gap = idle_len();
				end
			end else
				in_valid <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Output stall driver
	// ---------------------------------------------------------------

	int stall_left = 0;
	int rx_calm = 0;

	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (stall_left > 0)
				stall_left--;
			else if (rx_calm > 0)
				rx_calm--;
			else begin
				if ($urandom_range(0, 29) == 0)
					rx_calm = $urandom_range(15, 40);
				stall_left = idle_len();
			end
			out_stall <= hold_off || (stall_left > 0);
		end
	end

	// long receiver hold-off so the result buffer fills and backs up the input
	initial begin
		while (beats_accepted < 60)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// ---------------------------------------------------------------
	// Monitor and checker
	// ---------------------------------------------------------------

	function void field_check(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result();
		result_beat_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result beat with nothing expected, got kind %0d idx %0d",
				$time, result_kind, header_index);
			$display("%0t:   byte %0h reason %0d", $time, out_byte, error_reason);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		kinds_seen[want.kind]++;
		if (want.kind == KIND_REJECT)
			reasons_seen[want.reason]++;
		field_check("result_kind", 8'(want.kind), 8'(result_kind));
		field_check("header_index", 8'(want.idx), 8'(header_index));
		field_check("out_byte", want.data, out_byte);
		field_check("error_reason", 8'(want.reason), 8'(error_reason));
		field_check("last_result", 8'(want.last), 8'(last_result));
	endfunction

	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_beat(in_byte, in_last);
				beats_accepted++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				check_result();
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence: stimulus, reset, drain, verdict
	// ---------------------------------------------------------------

	initial begin
		int first, hdrs, n, cut, damage, k;
		beat_t t;

		foreach (kinds_seen[i]) begin
			kinds_seen[i] = 0;
			reasons_seen[i] = 0;
		end

		// full request: lone CR right after a skipped value prefix, taken as the first value byte, lone LF as content
		add_text("M P V");
		add_crlf();
		add_text("k: ");
		add_beat(CH_CR, 1'b0);
		add_text("v");
		add_beat(CH_LF, 1'b0);
		add_crlf();
		add_crlf();
		mark_last();
		// line end inside the method, then a dropped all-ones byte closes the buffer
		add_crlf();
		add_beat(8'hff, 1'b1);
		// zero byte on the last beat
		add_beat(CH_NUL, 1'b1);
		// buffer ends on a held CR
		add_text("X");
		add_beat(CH_CR, 1'b1);

		// header count runs out: every header index, then one header too many
		add_text("A B C");
		add_crlf();
		for (int i = 0; i < HEADER_LIMIT; i++) begin
			add_beat(CH_COLON, 1'b0);
			add_crlf();
		end
		add_beat(CH_COLON, 1'b0);
		mark_last();

		// random requests: mostly well formed, some noise, some cut short or zeroed
		while (request_beats.size() < STIM_TARGET) begin
			first = request_beats.size();
			if ($urandom_range(0, 99) < 12) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					add_beat(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				add_field(field_len(METHOD_LIMIT), 1'b0);
				add_beat(CH_SPACE, 1'b0);
				add_field(field_len(PATH_LIMIT), 1'b0);
				add_beat(CH_SPACE, 1'b0);
				add_field(field_len(VERSION_LIMIT), 1'b1);
				add_crlf();
				hdrs = $urandom_range(0, 3);
				for (int i = 0; i < hdrs; i++) begin
					add_field(field_len(NAME_LIMIT), 1'b0);
					if ($urandom_range(0, 14) != 0)
						add_beat(CH_COLON, 1'b0);
					for (int j = $urandom_range(0, 2); j > 0; j--)
						add_beat(CH_SPACE, 1'b0);
					add_field(field_len(VALUE_LIMIT), 1'b1);
					add_crlf();
				end
				add_crlf();
				for (int j = $urandom_range(0, 2); j > 0; j--)
					add_beat(8'($urandom_range(1, 255)), 1'b0);
				damage = $urandom_range(0, 99);
				if (damage < 15) begin
					cut = $urandom_range(first + 1, request_beats.size() - 1);
					while (request_beats.size() > cut)
						void'(request_beats.pop_back());
				end else if (damage < 25) begin
					k = $urandom_range(first, request_beats.size() - 1);
					t = request_beats[k];
					t.b = CH_NUL;
					request_beats[k] = t;
				end
			end
			mark_last();
		end
		beats_total = request_beats.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_accepted < beats_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			errors++;
		end

		$display("Run covered %0d request bytes and %0d result beats (%0d header ends, %0d accepts).",
			beats_accepted, results_seen, kinds_seen[KIND_HDONE], kinds_seen[KIND_ACCEPT]);
		$display("Rejects by reason: ended %0d, malformed %0d, too long %0d,",
			reasons_seen[RSN_ENDED], reasons_seen[RSN_MALFORMED], reasons_seen[RSN_TOO_LONG]);
		$display("  too many %0d, no colon %0d.",
			reasons_seen[RSN_TOO_MANY], reasons_seen[RSN_NO_COLON]);
		if (errors == 0)
			$display("http_request_head_parser_core: match");
		else
			$display("http_request_head_parser_core: mismatch");
		$finish;
	end

	// hang guard
	initial begin
		#(WATCHDOG_NS);
		$display("%0t: timeout, %0d of %0d bytes accepted, %0d results pending",
			$time, beats_accepted, beats_total, expected_results.size());
		$display("http_request_head_parser_core: mismatch");
		$finish;
	end

endmodule

[sim.f]
hdl/hrp_pkg.sv
hdl/hrp_step.sv
hdl/http_request_head_parser_core.sv
tb/sv/testbench.sv
